// File: hdl/egcd_pkg.sv
// egcd_pkg: shared types for the Euclid gcd block.
// Holds the sequencer state encoding and the control/status bundles
// passed between the sequencer and the datapath. No dependencies.
package egcd_pkg;

  // One-hot sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_ALIGN  = 6'b000100,
    ST_REDUCE = 6'b001000,
    ST_SWAP   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // Datapath commands from the sequencer
  typedef struct packed {
    logic load;      // capture a new request
    logic align;     // subtractor compares against divisor doubled
    logic shift_up;  // double the working divisor while it fits under y
    logic reduce;    // conditional subtract, halve the working divisor
    logic swap;      // (x, y) <= (y mod x, x)
  } ctrl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic x_zero;    // first operand is zero, y holds the result
    logic can_shift; // doubled divisor still fits under y
    logic last_step; // working divisor is back at x
  } stat_t;

endpackage

// File: hdl/egcd_alu.sv
// egcd_alu: operand registers and the shared shift-subtract unit.
// Computes y mod x by aligning a working divisor and subtracting back down.
// Depends on egcd_pkg.
module egcd_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  egcd_pkg::ctrl_t       ctrl,
  input  logic [DATA_WIDTH-1:0] first_value,
  input  logic [DATA_WIDTH-1:0] second_value,
  output egcd_pkg::stat_t       stat,
  output logic [DATA_WIDTH-1:0] result
);
  import egcd_pkg::*;

  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [DATA_WIDTH-1:0] d_r, d_nxt;
  logic [DATA_WIDTH:0]   opnd;
  logic [DATA_WIDTH+1:0] diff;
  logic                  ge;

  // single subtractor; extra top bit is the borrow
  assign opnd = ctrl.align ? {d_r, 1'b0} : {1'b0, d_r};
  assign diff = {2'b00, y_r} - {1'b0, opnd};
  assign ge   = ~diff[DATA_WIDTH+1];

  assign stat.x_zero    = (x_r == '0);
  assign stat.can_shift = ~d_r[DATA_WIDTH-1] & ge;
  assign stat.last_step = (d_r == x_r);
  assign result         = y_r;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    d_nxt = d_r;
    if (ctrl.load) begin
      x_nxt = first_value;
      y_nxt = second_value;
      d_nxt = first_value;
    end else if (ctrl.shift_up) begin
      if (stat.can_shift) begin
        d_nxt = {d_r[DATA_WIDTH-2:0], 1'b0};
      end
    end else if (ctrl.reduce) begin
      if (ge) begin
        y_nxt = diff[DATA_WIDTH-1:0];
      end
      d_nxt = {1'b0, d_r[DATA_WIDTH-1:1]};
    end else if (ctrl.swap) begin
      x_nxt = y_r;
      y_nxt = x_r;
      d_nxt = y_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    d_r <= d_nxt;
  end

endmodule

// File: hdl/egcd_ctrl.sv
// egcd_ctrl: sequencer for the gcd datapath.
// Steps load, align, reduce and swap until the first operand is zero.
// Depends on egcd_pkg.
module egcd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  egcd_pkg::stat_t stat,
  output egcd_pkg::ctrl_t ctrl
);
  import egcd_pkg::*;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = stat.x_zero ? ST_DONE : ST_ALIGN;
      end
      ST_ALIGN: begin
        // datapath only doubles while the doubled divisor fits
        ctrl.align    = 1'b1;
        ctrl.shift_up = 1'b1;
        if (!stat.can_shift) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        ctrl.reduce = 1'b1;
        // divisor back at x: remainder is final after this subtract
        if (stat.last_step) begin
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        ctrl.swap = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/euclid_gcd.sv
// euclid_gcd: top level of the Euclid greatest common divisor block.
// Instantiates egcd_ctrl and egcd_alu; depends on egcd_pkg.
//
// Takes one request of two unsigned operands and returns their greatest
// common divisor; gcd(0,b)=b, gcd(a,0)=a, gcd(0,0)=0. One request is in
// flight at a time: in_tready is high only while idle, and the result is
// held on out_tdata until taken. Each remainder step y mod x runs on one
// shared (DATA_WIDTH+2)-bit subtractor: a zero check, compares that double
// the divisor up to the dividend, compare-subtracts that halve it back down
// to x, then a swap. Consecutive Fibonacci operands need the most remainder
// steps.
module euclid_gcd #(
  parameter int DATA_WIDTH = 32,
  localparam int InWidth  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OutWidth = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InWidth-1:0]  in_tdata,  // first_value, second_value
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutWidth-1:0] out_tdata  // divisor
);
  import egcd_pkg::*;

  ctrl_t                 ctrl;
  stat_t                 stat;
  logic [DATA_WIDTH-1:0] result;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  egcd_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk          (clk),
    .ctrl         (ctrl),
    .first_value  (in_tdata[DATA_WIDTH-1:0]),
    .second_value (in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .stat         (stat),
    .result       (result)
  );

  assign out_tdata = OutWidth'(result);

  // busy from the cycle after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a request while one is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("ready for input while a result is pending");

  // zero first operand: second comes straight back, by way of the check state
  a_zero_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[DATA_WIDTH-1:0] == '0)
    |-> ##2 out_tvalid
        && (out_tdata[DATA_WIDTH-1:0] == $past(in_tdata[2*DATA_WIDTH-1:DATA_WIDTH], 2)))
    else $error("gcd with zero first operand is wrong");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && (out_tdata[DATA_WIDTH-1:0] == '0) |-> $past(stat.x_zero))
    else $error("zero result without a zero check");

endmodule

// File: verif/tb_euclid_gcd.sv
// tb_euclid_gcd: self-checking testbench for the euclid_gcd block.
// Drives operand pairs over the input stream, predicts each gcd locally and
// checks every returned divisor in order. Depends only on the RTL top level.
module tb_euclid_gcd;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Width = 32;
  localparam logic [Width-1:0] AllOnes = '1;

  typedef enum int {
    PK_FULL,
    PK_SHARED,
    PK_SMALL,
    PK_POW2,
    PK_ZERO,
    PK_EQUAL
  } pair_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [2*Width-1:0] in_tdata = '0;   // first_value, second_value
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [Width-1:0]   out_tdata;       // divisor

  logic [Width-1:0] divisor_q[$];
  int  mismatches = 0;
  int  pairs_sent = 0;
  int  divisors_seen = 0;
  int  zero_pairs = 0;
  bit  steady = 1'b0;

  euclid_gcd #(.DATA_WIDTH(Width)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [Width-1:0] euclid_divisor(input logic [Width-1:0] a,
                                                      input logic [Width-1:0] b);
    logic [Width-1:0] x;
    logic [Width-1:0] y;
    logic [Width-1:0] r;
    x = a;
    y = b;
    while (x != '0) begin
      r = y % x;
      y = x;
      x = r;
    end
    return y;
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 33);
  endfunction

  // One request; valid is left high so a following request can reuse it
  task automatic send_pair(input logic [Width-1:0] a, input logic [Width-1:0] b);
    if (idle_now()) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    divisor_q.push_back(euclid_divisor(a, b));
    pairs_sent++;
    if (a == '0 || b == '0) zero_pairs++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (divisor_q.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      divisors_seen++;
      if (divisor_q.size() == 0) begin
        mismatches++;
        $display("%0t: divisor %0d returned with no request pending", $time, out_tdata);
      end else begin
        if (out_tdata !== divisor_q[0]) begin
          mismatches++;
          $display("%0t: divisor mismatch, expected %0d, actual %0d",
                   $time, divisor_q[0], out_tdata);
        end
        void'(divisor_q.pop_front());
      end
    end
    out_tready <= !idle_now();
  end

  task automatic test_zero_operands();
    send_pair('0, '0);
    send_pair('0, AllOnes);
    send_pair(AllOnes, '0);
    send_pair('0, 32'd1);
    send_pair(32'd1, '0);
    send_pair('0, 32'h8000_0000);
    send_pair(32'd360, '0);
  endtask

  task automatic test_extremes();
    send_pair(AllOnes, AllOnes);
    send_pair(32'd1, AllOnes);
    send_pair(AllOnes, 32'd1);
    send_pair(AllOnes, AllOnes - 1);
    send_pair(32'd1, 32'd1);
    send_pair(32'h8000_0000, 32'h4000_0000);
    send_pair(32'h0000_0001, 32'h8000_0000);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'd12, 32'd18);
  endtask

  // Consecutive Fibonacci numbers need the most remainder steps (first three pairs)
  task automatic test_long_chains();
    send_pair(32'd1836311903, 32'd2971215073);
    send_pair(32'd2971215073, 32'd1836311903);
    send_pair(32'd1134903170, 32'd1836311903);
    send_pair(32'd3, 32'd4294967294);
    send_pair(32'd4294967291, 32'd4294967279);
  endtask

  task automatic send_random_pair();
    pair_kind_t kind;
    logic [Width-1:0] a;
    logic [Width-1:0] b;
    logic [Width-1:0] g;
    kind = pair_kind_t'($urandom_range(PK_FULL, PK_EQUAL));
    a = $urandom;
    b = $urandom;
    unique case (kind)
      PK_SHARED: begin
        g = $urandom_range(1, 65535);
        a = g * $urandom_range(0, 65535);
        b = g * $urandom_range(0, 65535);
      end
      PK_SMALL: begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      PK_POW2: begin
        a = Width'(1) << $urandom_range(0, Width - 1);
        b = b << $urandom_range(0, Width - 1);
      end
      PK_ZERO: begin
        if ($urandom_range(1)) a = '0;
        else b = '0;
      end
      PK_EQUAL: b = a;
      default: ;
    endcase
    send_pair(a, b);
  endtask

  task automatic test_random_pairs(input int count);
    repeat (count) send_random_pair();
  endtask

  // A long run without idling on either side
  task automatic test_steady_stream(input int count);
    steady = 1'b1;
    repeat (count) send_random_pair();
    drain();
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_operands();
    test_extremes();
    test_long_chains();
    drain();
    test_random_pairs(500);
    test_steady_stream(200);
    test_random_pairs(450);
    drain();
    repeat (300) @(posedge clk);

    $display("%0d operand pairs sent (%0d with a zero operand), %0d divisors checked",
             pairs_sent, zero_pairs, divisors_seen);
    if (mismatches == 0 && divisor_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/egcd_pkg.sv
hdl/egcd_alu.sv
hdl/egcd_ctrl.sv
hdl/euclid_gcd.sv
verif/tb_euclid_gcd.sv
